// ===== rtl/grwh_pkg.sv =====
`timescale 1ns / 1ps

package grwh_pkg;

    // Map and fixed point geometry
    localparam int TILE_PIXELS   = 64;
    localparam int FRACTION_BITS = 8;
    localparam int MAX_MAP_COLS  = 32;
    localparam int MAX_MAP_ROWS  = 16;
    localparam int TILE_SH       = $clog2(TILE_PIXELS) + FRACTION_BITS;
    localparam int TILE_Q        = 1 << TILE_SH;
    localparam int MAP_COL_W     = $clog2(MAX_MAP_COLS);
    localparam int MAP_ROW_W     = $clog2(MAX_MAP_ROWS);
    localparam int MAP_AW        = MAP_COL_W + MAP_ROW_W;
    localparam int MAP_CELLS     = MAX_MAP_COLS * MAX_MAP_ROWS;
    localparam int LIM_W         = 6;

    // Datapath widths
    localparam int POS_W   = 20;             // positions and hit coordinates
    localparam int COORD_W = 23;             // signed walk coordinates
    localparam int IDX_W   = COORD_W - 1 - TILE_SH;
    localparam int OFF_W   = 21;
    localparam int MAG_W   = 17;             // direction magnitudes
    localparam int CS_W    = 19;             // CORDIC vector parts, signed
    localparam int Z_W     = 16;
    localparam int PROD_W  = OFF_W + MAG_W;
    localparam int QUO_W   = 21;
    localparam int NUM_W   = 42;
    localparam int SQ_W    = 40;
    localparam int ROOT_W  = 21;
    localparam int DIST_W  = 20;
    localparam int DIR_GAIN = 65536;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_RAY   = 1'b1;

    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    localparam logic [15:0] ANGLE_HALF    = 16'd32768;
    localparam logic [15:0] ANGLE_QUARTER = 16'd16384;
    localparam logic [15:0] ANGLE_3QUART  = 16'd49152;

    typedef enum logic {
        AR_DIV,
        AR_SQRT
    } t_ar_op;

    typedef struct packed {
        logic   start;
        t_ar_op op;
    } t_ar_cmd;

    typedef struct packed {
        logic        is_ray;
        logic [3:0]  row;
        logic [4:0]  col;
        logic [7:0]  value;
        logic [18:0] px;
        logic [17:0] py;
        logic [15:0] angle;
        logic        down;
        logic        right;
    } t_item;

    typedef struct packed {
        logic        found;
        logic        vertical;
        logic [18:0] x;
        logic [17:0] y;
        logic [7:0]  value;
        logic [19:0] distance;
        logic        down;
        logic        right;
    } t_result;

    // CORDIC arctangent steps in binary angle units
    function automatic logic [13:0] atan_units(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/grwh_front.sv =====
`timescale 1ns / 1ps

module grwh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_mode,
    input  logic [3:0]          i_tile_row,
    input  logic [4:0]          i_tile_col,
    input  logic [7:0]          i_tile_value,
    input  logic [18:0]         i_player_x,
    input  logic [17:0]         i_player_y,
    input  logic [15:0]         i_ray_angle,
    output logic                o_valid,
    output grwh_pkg::t_item     o_item,
    input  logic                i_pop
);

    grwh_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    grwh_pkg::t_item cls;
    logic            wr;

    // classify: mode decode and facing flags
    always_comb begin
        cls.is_ray = (i_mode == grwh_pkg::MODE_RAY);
        cls.row    = i_tile_row;
        cls.col    = i_tile_col;
        cls.value  = i_tile_value;
        cls.px     = i_player_x;
        cls.py     = i_player_y;
        cls.angle  = i_ray_angle;
        cls.down   = (i_ray_angle != 16'd0) && (i_ray_angle < grwh_pkg::ANGLE_HALF);
        cls.right  = (i_ray_angle < grwh_pkg::ANGLE_QUARTER) ||
                     (i_ray_angle > grwh_pkg::ANGLE_3QUART);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign wr      = i_push && !o_full;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/grwh_divsqrt.sv =====
`timescale 1ns / 1ps

// Shared radix-2 unit: saturating divide or integer square root, one bit a cycle.
module grwh_divsqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  grwh_pkg::t_ar_cmd             i_cmd,
    input  logic [grwh_pkg::NUM_W-1:0]    i_num,
    input  logic [grwh_pkg::MAG_W-1:0]    i_den,
    output logic                          o_done,
    output logic [grwh_pkg::ROOT_W-1:0]   o_res
);

    localparam int REM_W = 24;

    logic                          r_busy;
    logic                          r_done;
    grwh_pkg::t_ar_op              r_op;
    logic [4:0]                    r_cnt;
    logic [grwh_pkg::NUM_W-1:0]    r_num;
    logic [REM_W-1:0]              r_rem;
    logic [grwh_pkg::ROOT_W-1:0]   r_res;
    logic [grwh_pkg::MAG_W-1:0]    r_den;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic             ovf;

    assign ovf = (i_num[grwh_pkg::PROD_W-1:grwh_pkg::QUO_W] >= i_den);

    always_comb begin
        if (r_op == grwh_pkg::AR_DIV) begin
            rem_sh = {r_rem[REM_W-2:0], r_num[grwh_pkg::NUM_W-1]};
            trial  = REM_W'(r_den);
        end else begin
            rem_sh = {r_rem[REM_W-3:0], r_num[grwh_pkg::NUM_W-1 -: 2]};
            trial  = REM_W'({r_res, 2'b01});
        end
        ge = (rem_sh >= trial);
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_op  <= i_cmd.op;
                r_den <= i_den;
                r_cnt <= 5'(grwh_pkg::QUO_W - 1);
                if (i_cmd.op == grwh_pkg::AR_DIV) begin
                    r_rem <= REM_W'(i_num[grwh_pkg::PROD_W-1:grwh_pkg::QUO_W]);
                    r_num <= {i_num[grwh_pkg::QUO_W-1:0],
                              (grwh_pkg::NUM_W - grwh_pkg::QUO_W)'(0)};
                    if (ovf) begin
                        // quotient does not fit: saturate, caller treats it as off map
                        r_res  <= '1;
                        r_done <= 1'b1;
                    end else begin
                        r_res  <= '0;
                        r_busy <= 1'b1;
                    end
                end else begin
                    r_rem  <= '0;
                    r_num  <= i_num;
                    r_res  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? rem_sh - trial : rem_sh;
                r_res <= {r_res[grwh_pkg::ROOT_W-2:0], ge};
                r_num <= (r_op == grwh_pkg::AR_DIV) ? {r_num[grwh_pkg::NUM_W-2:0], 1'b0}
                                                    : {r_num[grwh_pkg::NUM_W-3:0], 2'b00};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/grwh_back.sv =====
`timescale 1ns / 1ps

module grwh_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  grwh_pkg::t_item               i_item,
    output logic                          o_item_pop,
    input  logic [grwh_pkg::LIM_W-1:0]    i_lim_w,
    input  logic [grwh_pkg::LIM_W-1:0]    i_lim_h,
    output logic                          o_res_valid,
    output grwh_pkg::t_result             o_res,
    input  logic                          i_res_pop
);

    localparam int CW = grwh_pkg::COORD_W;
    localparam int PW = grwh_pkg::POS_W;
    localparam logic signed [CW-1:0] TILE_STEP = CW'(grwh_pkg::TILE_Q);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_CSEL,
        ST_WINIT,
        ST_WMUL,
        ST_WDIV,
        ST_WCHK,
        ST_WMEM,
        ST_WEND,
        ST_DSQX,
        ST_DSQY,
        ST_DROOT,
        ST_DNEXT,
        ST_DONE
    } t_state;

    t_state                            r_state;
    logic [18:0]                       r_px;
    logic [17:0]                       r_py;
    logic                              r_qodd;
    logic                              r_down;
    logic                              r_right;
    logic signed [grwh_pkg::CS_W-1:0]  r_c;
    logic signed [grwh_pkg::CS_W-1:0]  r_s;
    logic signed [grwh_pkg::Z_W-1:0]   r_z;
    logic [3:0]                        r_it;
    logic [grwh_pkg::MAG_W-1:0]        r_mx;
    logic [grwh_pkg::MAG_W-1:0]        r_my;
    logic                              r_vert;
    logic signed [CW-1:0]              r_line;
    logic signed [CW-1:0]              r_other;
    logic [grwh_pkg::PROD_W-1:0]       r_prod;
    logic [grwh_pkg::SQ_W-1:0]         r_sq;
    logic [grwh_pkg::NUM_W-1:0]        r_sum;
    grwh_pkg::t_ar_cmd                 r_ar_cmd;
    logic                              r_hf, r_vf;
    logic [PW-1:0]                     r_hx, r_hy, r_vx, r_vy;
    logic [7:0]                        r_hval, r_vval;
    logic [grwh_pkg::ROOT_W-1:0]       r_hd, r_vd;
    logic                              r_out_valid;
    grwh_pkg::t_result                 r_out;

    // tile map: undefined until software writes it
    logic [7:0]                        r_map [grwh_pkg::MAP_CELLS];
    logic [7:0]                        r_rdata;

    // walk axis selection
    logic [PW-1:0]                     p_cross, p_other;
    logic [grwh_pkg::MAG_W-1:0]        m_cross, m_other;
    logic                              pos_cross, pos_other;
    logic [grwh_pkg::LIM_W-1:0]        lim_cross, lim_other;

    // datapath
    logic signed [grwh_pkg::CS_W-1:0]  sh_c, sh_s;
    logic signed [grwh_pkg::Z_W-1:0]   atan_s;
    logic [grwh_pkg::MAG_W-1:0]        cl_c, cl_s;
    logic signed [CW-1:0]              line_base;
    logic signed [CW-1:0]              diff;
    logic [grwh_pkg::OFF_W-1:0]        off;
    logic signed [CW-1:0]              mag_s;
    logic signed [CW-1:0]              ccheck;
    logic [grwh_pkg::IDX_W-1:0]        ci, oi;
    logic                              leave;
    logic [grwh_pkg::MAP_ROW_W-1:0]    rd_row;
    logic [grwh_pkg::MAP_COL_W-1:0]    rd_col;
    logic                              rd_en;
    logic                              wr_en;
    logic [PW-1:0]                     side_x, side_y;
    logic signed [PW:0]                dx, dy;
    logic [PW-1:0]                     adx, ady;
    logic                              ar_done;
    logic [grwh_pkg::ROOT_W-1:0]       ar_res;
    logic [grwh_pkg::NUM_W-1:0]        ar_num;
    logic                              h_lt;
    logic [grwh_pkg::ROOT_W-1:0]       d_sel;
    grwh_pkg::t_result                 res;

    always_comb begin
        p_cross   = r_vert ? PW'(r_px) : PW'(r_py);
        p_other   = r_vert ? PW'(r_py) : PW'(r_px);
        m_cross   = r_vert ? r_mx : r_my;
        m_other   = r_vert ? r_my : r_mx;
        pos_cross = r_vert ? r_right : r_down;
        pos_other = r_vert ? r_down : r_right;
        lim_cross = r_vert ? i_lim_w : i_lim_h;
        lim_other = r_vert ? i_lim_h : i_lim_w;
    end

    // CORDIC micro-rotation
    always_comb begin
        sh_c   = r_c >>> r_it;
        sh_s   = r_s >>> r_it;
        atan_s = signed'(grwh_pkg::Z_W'(grwh_pkg::atan_units(r_it)));
        cl_c   = r_c[grwh_pkg::CS_W-1] ? '0 : r_c[grwh_pkg::MAG_W-1:0];
        cl_s   = r_s[grwh_pkg::CS_W-1] ? '0 : r_s[grwh_pkg::MAG_W-1:0];
    end

    // grid walk
    always_comb begin
        line_base = signed'(CW'(p_cross & ~PW'(grwh_pkg::TILE_Q - 1)))
                    + (pos_cross ? TILE_STEP : CW'(0));
        diff   = r_line - signed'(CW'(p_cross));
        off    = diff[CW-1] ? grwh_pkg::OFF_W'(-diff) : grwh_pkg::OFF_W'(diff);
        mag_s  = signed'(CW'(ar_res));
        ccheck = pos_cross ? r_line : r_line - CW'(1);
        ci     = ccheck[CW-2:grwh_pkg::TILE_SH];
        oi     = r_other[CW-2:grwh_pkg::TILE_SH];
        leave  = ccheck[CW-1] || r_other[CW-1] ||
                 (ci >= grwh_pkg::IDX_W'(lim_cross)) ||
                 (oi >= grwh_pkg::IDX_W'(lim_other));
        rd_row = r_vert ? oi[grwh_pkg::MAP_ROW_W-1:0] : ci[grwh_pkg::MAP_ROW_W-1:0];
        rd_col = r_vert ? ci[grwh_pkg::MAP_COL_W-1:0] : oi[grwh_pkg::MAP_COL_W-1:0];
        rd_en  = (r_state == ST_WCHK) && !leave;
    end

    // distance
    always_comb begin
        side_x = r_vert ? r_vx : r_hx;
        side_y = r_vert ? r_vy : r_hy;
        dx     = signed'({1'b0, side_x}) - signed'((PW + 1)'(r_px));
        dy     = signed'({1'b0, side_y}) - signed'((PW + 1)'(r_py));
        adx    = dx[PW] ? PW'(-dx) : PW'(dx);
        ady    = dy[PW] ? PW'(-dy) : PW'(dy);
        ar_num = (r_ar_cmd.op == grwh_pkg::AR_SQRT) ? r_sum : grwh_pkg::NUM_W'(r_prod);
    end

    // pick the nearer hit; vertical wins ties and stands for "no hit"
    always_comb begin
        h_lt = r_hf && (!r_vf || (r_hd < r_vd));
        d_sel = h_lt ? r_hd : r_vd;
        res.found    = r_hf || r_vf;
        res.vertical = !h_lt;
        res.x        = h_lt ? r_hx[18:0] : r_vx[18:0];
        res.y        = h_lt ? r_hy[17:0] : r_vy[17:0];
        res.value    = h_lt ? r_hval : r_vval;
        res.distance = (!res.found || d_sel[grwh_pkg::ROOT_W-1]) ? '1
                                                                : d_sel[grwh_pkg::DIST_W-1:0];
        res.down     = r_down;
        res.right    = r_right;
    end

    assign o_item_pop  = (r_state == ST_IDLE) && i_item_valid;
    assign wr_en       = o_item_pop && !i_item.is_ray;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[{i_item.row, i_item.col}] <= i_item.value;
        end
        if (rd_en) begin
            r_rdata <= r_map[{rd_row, rd_col}];
        end
    end

    grwh_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_ar_cmd),
        .i_num   (ar_num),
        .i_den   (m_cross),
        .o_done  (ar_done),
        .o_res   (ar_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ar_cmd      <= '{start: 1'b0, op: grwh_pkg::AR_DIV};
            r_out_valid   <= 1'b0;
            r_vert        <= 1'b0;
        end else begin
            r_ar_cmd.start <= 1'b0;
            if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid && i_item.is_ray) begin
                        r_px    <= i_item.px;
                        r_py    <= i_item.py;
                        r_qodd  <= i_item.angle[14];
                        r_down  <= i_item.down;
                        r_right <= i_item.right;
                        r_c     <= grwh_pkg::CS_W'(grwh_pkg::DIR_GAIN);
                        r_s     <= '0;
                        r_z     <= grwh_pkg::Z_W'(i_item.angle[13:0]);
                        r_it    <= '0;
                        r_vert  <= 1'b0;
                        r_hf    <= 1'b0;
                        r_vf    <= 1'b0;
                        r_hx    <= '0;
                        r_hy    <= '0;
                        r_vx    <= '0;
                        r_vy    <= '0;
                        r_hval  <= '0;
                        r_vval  <= '0;
                        r_state <= (i_item.angle[13:0] == 14'd0) ? ST_CSEL : ST_CORDIC;
                    end
                end
                ST_CORDIC: begin
                    if (!r_z[grwh_pkg::Z_W-1]) begin
                        r_c <= r_c - sh_s;
                        r_s <= r_s + sh_c;
                        r_z <= r_z - atan_s;
                    end else begin
                        r_c <= r_c + sh_s;
                        r_s <= r_s - sh_c;
                        r_z <= r_z + atan_s;
                    end
                    r_it <= r_it + 4'd1;
                    if (r_it == 4'd15) begin
                        r_state <= ST_CSEL;
                    end
                end
                ST_CSEL: begin
                    r_mx    <= r_qodd ? cl_s : cl_c;
                    r_my    <= r_qodd ? cl_c : cl_s;
                    r_state <= ST_WINIT;
                end
                ST_WINIT: begin
                    // no motion across this axis: no line is ever crossed
                    if (m_cross == '0) begin
                        r_state <= ST_WEND;
                    end else begin
                        r_line  <= line_base;
                        r_state <= ST_WMUL;
                    end
                end
                ST_WMUL: begin
                    r_prod         <= off * m_other;
                    r_ar_cmd.start <= 1'b1;
                    r_ar_cmd.op    <= grwh_pkg::AR_DIV;
                    r_state        <= ST_WDIV;
                end
                ST_WDIV: begin
                    if (ar_done) begin
                        r_other <= pos_other ? signed'(CW'(p_other)) + mag_s
                                             : signed'(CW'(p_other)) - mag_s;
                        r_state <= ST_WCHK;
                    end
                end
                ST_WCHK: begin
                    r_state <= leave ? ST_WEND : ST_WMEM;
                end
                ST_WMEM: begin
                    if (r_rdata != 8'd0) begin
                        if (r_vert) begin
                            r_vf   <= 1'b1;
                            r_vval <= r_rdata;
                            r_vx   <= PW'(r_line);
                            r_vy   <= PW'(r_other);
                        end else begin
                            r_hf   <= 1'b1;
                            r_hval <= r_rdata;
                            r_hx   <= PW'(r_other);
                            r_hy   <= PW'(r_line);
                        end
                        r_state <= ST_WEND;
                    end else begin
                        r_line  <= pos_cross ? r_line + TILE_STEP : r_line - TILE_STEP;
                        r_state <= ST_WMUL;
                    end
                end
                ST_WEND: begin
                    r_vert  <= ~r_vert;
                    r_state <= r_vert ? ST_DSQX : ST_WINIT;
                end
                ST_DSQX: begin
                    if ((r_vert ? r_vf : r_hf)) begin
                        r_sq    <= adx * adx;
                        r_state <= ST_DSQY;
                    end else begin
                        r_state <= ST_DNEXT;
                    end
                end
                ST_DSQY: begin
                    r_sum          <= grwh_pkg::NUM_W'(r_sq) + grwh_pkg::NUM_W'(ady * ady);
                    r_ar_cmd.start <= 1'b1;
                    r_ar_cmd.op    <= grwh_pkg::AR_SQRT;
                    r_state        <= ST_DROOT;
                end
                ST_DROOT: begin
                    if (ar_done) begin
                        if (r_vert) begin
                            r_vd <= ar_res;
                        end else begin
                            r_hd <= ar_res;
                        end
                        r_state <= ST_DNEXT;
                    end
                end
                ST_DNEXT: begin
                    r_vert  <= ~r_vert;
                    r_state <= r_vert ? ST_DONE : ST_DSQX;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_res_pop) begin
                        r_out       <= res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/grid_ray_wall_hit.sv =====
`timescale 1ns / 1ps

// Grid ray caster with an on-chip tile map (32 x 16 tiles of 8 bits).
// Input side is a queue: an item is taken when push is high and full is low.
// Mode 0 writes one tile and produces no result; mode 1 casts one ray.
// Result side is a queue: the result sits on o_* while empty is low and is
// taken when pop is high. Config writes (i_cfg_we) set the map size in use
// and must be made only while the block is idle; the block does not
// enforce this. A ray goes into the worker, gets its CORDIC direction,
// then per crossed grid line a multiply, a radix-2 divide and a map read,
// then up to two distance square roots on the shared divide/root unit.
// A tile write is done straight from the idle state.
// Two items can wait in the input queue while a ray is worked on, and the
// worker keeps running while one finished result waits to be popped; it
// stalls only when a second result is ready and the first is still held.
// Reset empties both queues and sets the map size to 32 x 16; map contents
// are undefined until written.
module grid_ray_wall_hit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [3:0]  i_tile_row,
    input  logic [4:0]  i_tile_col,
    input  logic [7:0]  i_tile_value,
    input  logic [18:0] i_player_x,
    input  logic [17:0] i_player_y,
    input  logic [15:0] i_ray_angle,
    output logic        empty,
    input  logic        pop,
    output logic        o_hit_found,
    output logic        o_hit_vertical,
    output logic [18:0] o_hit_x,
    output logic [17:0] o_hit_y,
    output logic [7:0]  o_wall_value,
    output logic [19:0] o_hit_distance,
    output logic        o_facing_down,
    output logic        o_facing_right,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);

    logic [5:0]              r_map_w;
    logic [4:0]              r_map_h;
    logic [grwh_pkg::LIM_W-1:0] lim_w, lim_h;

    grwh_pkg::t_item         item;
    logic                    item_valid;
    logic                    item_pop;
    logic                    res_valid;
    grwh_pkg::t_result       res;
    logic                    res_pop;

    // config registers; sizes above 32 x 16 clamp to 32 x 16, the height takes only i_cfg_data[4:0]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 6'd32;
            r_map_h <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grwh_pkg::CFG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                grwh_pkg::CFG_MAP_HEIGHT: r_map_h <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign lim_w = (r_map_w > 6'(grwh_pkg::MAX_MAP_COLS)) ? 6'(grwh_pkg::MAX_MAP_COLS)
                                                          : r_map_w;
    assign lim_h = (r_map_h > 5'(grwh_pkg::MAX_MAP_ROWS)) ? 6'(grwh_pkg::MAX_MAP_ROWS)
                                                          : 6'(r_map_h);

    // front: accept and classify, two-entry queue to the worker
    grwh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_tile_row   (i_tile_row),
        .i_tile_col   (i_tile_col),
        .i_tile_value (i_tile_value),
        .i_player_x   (i_player_x),
        .i_player_y   (i_player_y),
        .i_ray_angle  (i_ray_angle),
        .o_valid      (item_valid),
        .o_item       (item),
        .i_pop        (item_pop)
    );

    // back: map memory, direction, grid walk, distance, result register
    grwh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_lim_w      (lim_w),
        .i_lim_h      (lim_h),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_pop    (res_pop)
    );

    assign empty   = !res_valid;
    assign res_pop = pop && res_valid;

    assign o_hit_found    = res.found;
    assign o_hit_vertical = res.vertical;
    assign o_hit_x        = res.x;
    assign o_hit_y        = res.y;
    assign o_wall_value   = res.value;
    assign o_hit_distance = res.distance;
    assign o_facing_down  = res.down;
    assign o_facing_right = res.right;

    // a miss reports the vertical side, zero point and a saturated distance
    a_miss_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit_found) |->
            (o_hit_vertical && o_hit_x == '0 && o_hit_y == '0 && o_wall_value == '0 &&
             o_hit_distance == '1))
        else $error("miss result malformed");

    // a real hit inside the map is always nearer than the saturation value
    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_hit_found) |-> (o_hit_distance != '1))
        else $error("hit with saturated distance");

    // both queues come up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

// ===== verif/grid_ray_wall_hit_test.sv =====
`timescale 1ns / 1ps

module grid_ray_wall_hit_test;

    // Run limits: a ray crosses at most ~50 lines, each with a divide, plus
    // CORDIC and roots; each transaction may also wait out a random gap.
    localparam int  DRAIN_CYCLES = 2000;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint TILE_QU = longint'(grwh_pkg::TILE_PIXELS) << grwh_pkg::FRACTION_BITS;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_mode = grwh_pkg::MODE_WRITE;
    logic [3:0]  i_tile_row = '0;
    logic [4:0]  i_tile_col = '0;
    logic [7:0]  i_tile_value = '0;
    logic [18:0] i_player_x = '0;
    logic [17:0] i_player_y = '0;
    logic [15:0] i_ray_angle = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_hit_found;
    logic        o_hit_vertical;
    logic [18:0] o_hit_x;
    logic [17:0] o_hit_y;
    logic [7:0]  o_wall_value;
    logic [19:0] o_hit_distance;
    logic        o_facing_down;
    logic        o_facing_right;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = grwh_pkg::CFG_MAP_WIDTH;
    logic [5:0]  i_cfg_data = '0;

    grid_ray_wall_hit u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: its own copy of the map and the size registers.
    logic [7:0]          tile_copy [grwh_pkg::MAP_CELLS];
    int                  cols_in_use = 32;
    int                  rows_in_use = 16;
    grwh_pkg::t_result   pending_hits [$];

    int     mismatches = 0;
    bit     failed = 0;
    bit     no_gaps = 0;     // burst stretches: both sides run without idling
    longint cycles = 0;

    const int arctan_steps [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1, 1, 0};

    typedef struct {
        bit     found;
        longint x;
        longint y;
        logic [7:0] value;
    } t_wall;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("grid_ray_wall_hit_test: errors");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 12);
    endfunction

    // Direction magnitudes: CORDIC rotation of (65536,0) by the quadrant offset.
    function automatic void ray_direction(input logic [15:0] ang,
                                          output longint mx, output longint my);
        longint c, s, nc, ns;
        int z;
        c = grwh_pkg::DIR_GAIN;
        s = 0;
        z = int'(ang[13:0]);
        if (z != 0) begin
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nc = c - (s >>> i);
                    ns = s + (c >>> i);
                    z -= arctan_steps[i];
                end else begin
                    nc = c + (s >>> i);
                    ns = s - (c >>> i);
                    z += arctan_steps[i];
                end
                c = nc;
                s = ns;
            end
            if (c < 0) c = 0;
            if (s < 0) s = 0;
        end
        if (!ang[14]) begin
            mx = c; my = s;
        end else begin
            mx = s; my = c;
        end
    endfunction

    // Step across grid lines of one axis until a wall or the map edge.
    function automatic t_wall trace_axis(bit vert, longint p_cross, longint p_other,
                                         longint m_cross, longint m_other,
                                         bit pos_cross, bit pos_other,
                                         longint lim_cross, longint lim_other);
        t_wall  h;
        longint line, off, other, chk, ci, oi, row, col;
        h = '{0, 0, 0, 8'd0};
        if (m_cross == 0) return h;  // parallel to these lines
        line = (p_cross / TILE_QU) * TILE_QU + (pos_cross ? TILE_QU : 0);
        for (longint n = 0; n < lim_cross + 2; n++) begin
            off = line - p_cross;
            if (off < 0) off = -off;
            other = pos_other ? p_other + (off * m_other) / m_cross
                              : p_other - (off * m_other) / m_cross;
            chk = pos_cross ? line : line - 1;
            if (chk < 0 || other < 0) return h;
            ci = chk / TILE_QU;
            oi = other / TILE_QU;
            if (ci >= lim_cross || oi >= lim_other) return h;
            row = vert ? oi : ci;
            col = vert ? ci : oi;
            if (tile_copy[row * grwh_pkg::MAX_MAP_COLS + col] != 0) begin
                h.found = 1;
                h.value = tile_copy[row * grwh_pkg::MAX_MAP_COLS + col];
                h.x = vert ? line : other;
                h.y = vert ? other : line;
                return h;
            end
            line += pos_cross ? TILE_QU : -TILE_QU;
        end
        return h;
    endfunction

    function automatic longint unsigned wall_range(t_wall h, longint px, longint py);
        longint unsigned v, r, b;
        longint dx, dy;
        if (!h.found) return '1;
        dx = h.x - px;
        dy = h.y - py;
        v = longint'(dx * dx) + longint'(dy * dy);
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic grwh_pkg::t_result cast_ray(logic [18:0] px, logic [17:0] py,
                                                   logic [15:0] ang);
        grwh_pkg::t_result r;
        longint mx, my;
        longint unsigned dh, dv, d;
        t_wall hh, vh, best;
        bit down, right;
        down  = ang > 0 && ang < grwh_pkg::ANGLE_HALF;
        right = ang < grwh_pkg::ANGLE_QUARTER || ang > grwh_pkg::ANGLE_3QUART;
        ray_direction(ang, mx, my);
        hh = trace_axis(0, py, px, my, mx, down, right, rows_in_use, cols_in_use);
        vh = trace_axis(1, px, py, mx, my, right, down, cols_in_use, rows_in_use);
        dh = wall_range(hh, px, py);
        dv = wall_range(vh, px, py);
        best = (dh < dv) ? hh : vh;          // tie goes to the vertical hit
        d = (dh < dv) ? dh : dv;
        r.found    = hh.found || vh.found;
        r.vertical = !(dh < dv);
        r.x        = best.x[18:0];
        r.y        = best.y[17:0];
        r.value    = best.value;
        r.distance = (d > 64'd1048575) ? 20'hFFFFF : d[19:0];
        r.down     = down;
        r.right    = right;
        return r;
    endfunction

    // One input transaction. push stays high across back-to-back items.
    task automatic send_item(logic mode, logic [3:0] row, logic [4:0] col,
                             logic [7:0] val, logic [18:0] px, logic [17:0] py,
                             logic [15:0] ang);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= mode;
        i_tile_row <= row;
        i_tile_col <= col;
        i_tile_value <= val;
        i_player_x <= px;
        i_player_y <= py;
        i_ray_angle <= ang;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // accepted at this edge: predict in order of acceptance
        if (mode == grwh_pkg::MODE_WRITE)
            tile_copy[{row, col}] = val;
        else
            pending_hits.push_back(cast_ray(px, py, ang));
    endtask

    task automatic send_ray(logic [18:0] px, logic [17:0] py, logic [15:0] ang);
        send_item(grwh_pkg::MODE_RAY, 4'($urandom), 5'($urandom), 8'($urandom),
                  px, py, ang);
    endtask

    task automatic send_tile(logic [3:0] row, logic [4:0] col, logic [7:0] val);
        send_item(grwh_pkg::MODE_WRITE, row, col, val, 19'($urandom), 18'($urandom),
                  16'($urandom));
    endtask

    // Quiesce: all results popped, then let a trailing write-only item finish.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_map_size(int w, int h);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= grwh_pkg::CFG_MAP_WIDTH;
        i_cfg_data <= w[5:0];
        @(posedge i_clk);
        i_cfg_idx <= grwh_pkg::CFG_MAP_HEIGHT;
        i_cfg_data <= h[5:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cols_in_use = (w[5:0] > grwh_pkg::MAX_MAP_COLS) ? grwh_pkg::MAX_MAP_COLS
                                                        : int'(w[5:0]);
        rows_in_use = (h[4:0] > grwh_pkg::MAX_MAP_ROWS) ? grwh_pkg::MAX_MAP_ROWS
                                                        : int'(h[4:0]);
    endtask

    // Result side: random pop gaps, compare each transaction with the oldest.
    initial begin
        int gap;
        grwh_pkg::t_result want;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (pending_hits.size() == 0) begin
                failed = 1;
                if (mismatches++ < 10) $display("unexpected result transaction");
            end else begin
                want = pending_hits.pop_front();
                if (o_hit_found !== want.found || o_hit_vertical !== want.vertical ||
                    o_hit_x !== want.x || o_hit_y !== want.y ||
                    o_wall_value !== want.value || o_hit_distance !== want.distance ||
                    o_facing_down !== want.down || o_facing_right !== want.right) begin
                    failed = 1;
                    if (mismatches++ < 10)
                        $display("mismatch exp f%0d v%0d x%0d y%0d w%0d d%0d dn%0d rt%0d / act f%0d v%0d x%0d y%0d w%0d d%0d dn%0d rt%0d",
                                 want.found, want.vertical, want.x, want.y, want.value,
                                 want.distance, want.down, want.right, o_hit_found,
                                 o_hit_vertical, o_hit_x, o_hit_y, o_wall_value,
                                 o_hit_distance, o_facing_down, o_facing_right);
                end
            end
        end
    end

    // Every tile written at least once so no ray reads undefined map contents.
    task automatic test_map_load();
        no_gaps = 1;
        for (int r = 0; r < grwh_pkg::MAX_MAP_ROWS; r++)
            for (int c = 0; c < grwh_pkg::MAX_MAP_COLS; c++)
                send_tile(4'(r), 5'(c),
                          ($urandom_range(0, 99) < 30) ? 8'($urandom_range(1, 255)) : 8'd0);
        send_tile(4'd15, 5'd31, 8'hFF);
        send_tile(4'd0, 5'd0, 8'h00);
        no_gaps = 0;
    endtask

    // Axis-aligned angles (parallel traversals), quadrant edges, position extremes.
    task automatic test_directed_rays();
        logic [15:0] angs [10] = '{16'd0, 16'd1, 16'd8192, 16'd16384, 16'd16385,
                                   16'd32768, 16'd40000, 16'd49152, 16'd49153,
                                   16'd65535};
        foreach (angs[i]) send_ray(19'(131072 + i * 4000), 18'd70000, angs[i]);
        send_ray(19'd0, 18'd0, 16'd8192);
        send_ray(19'h7FFFF, 18'h3FFFF, 16'd40960);
        send_ray(19'h7FFFF, 18'd0, 16'd24576);
        send_ray(19'd0, 18'h3FFFF, 16'd57344);
    endtask

    // Size extremes, including a zero size (nothing can be hit) and out of range.
    task automatic test_config_extremes();
        set_map_size(0, 16);
        send_ray(19'd100000, 18'd100000, 16'd5000);
        set_map_size(63, 31);
        send_ray(19'd100000, 18'd100000, 16'd37000);
        set_map_size(1, 1);
        send_ray(19'd8000, 18'd8000, 16'd3000);
        send_ray(19'd8000, 18'd8000, 16'd35000);
        set_map_size(32, 0);
        send_ray(19'd50000, 18'd50000, 16'd20000);
    endtask

    task automatic test_random_casting(int count);
        int pick;
        logic [15:0] ang;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_tile(4'($urandom), 5'($urandom),
                          $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'd0);
            end else begin
                ang = 16'($urandom);
                if (pick < 20) ang = {2'($urandom_range(0, 3)), 14'd0};
                send_ray(19'($urandom), 18'($urandom), ang);
            end
        end
        no_gaps = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_map_load();
        test_directed_rays();
        test_config_extremes();
        set_map_size(32, 16);
        test_random_casting(40);
        set_map_size($urandom_range(1, 32), $urandom_range(1, 16));
        test_random_casting(40);
        set_map_size($urandom_range(20, 32), $urandom_range(8, 16));
        test_random_casting(40);
        wait_idle();
        if (!failed)
            $display("grid_ray_wall_hit_test: clean");
        else
            $display("grid_ray_wall_hit_test: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/grwh_pkg.sv
rtl/grwh_front.sv
rtl/grwh_divsqrt.sv
rtl/grwh_back.sv
rtl/grid_ray_wall_hit.sv
verif/grid_ray_wall_hit_test.sv
